@@ rtl/slre_pkg.sv @@
// ----------------------------------------------------------------------------
// slre_pkg
// Types, register indexes and constants of the serial loaded ROM emulator.
// ----------------------------------------------------------------------------
package slre_pkg;

  localparam int unsigned ROM_BASE_DEF  = 57344;
  localparam int unsigned ROM_DEPTH_DEF = 8192;

  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_BYTE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR_COUNT = 2'd1;

  localparam logic [7:0] MARKER_RESET     = 8'hDE;
  localparam logic [2:0] TERM_COUNT_RESET = 3'd3;
  localparam logic [2:0] RUN_MAX          = 3'd7;

  // Number of vector bytes preset at the top of the ROM
  localparam int unsigned VEC_COUNT = 6;

  typedef struct packed {
    logic        action;
    logic [7:0]  serial_byte;
    logic [15:0] bus_address;
  } in_t;

  typedef struct packed {
    logic       drive_enable;
    logic [7:0] bus_data;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       load_done;
    logic       ready_led;
  } out_t;

  localparam logic ACT_SERIAL = 1'b0;
  localparam logic ACT_BUS    = 1'b1;

  // Reset content of the top six ROM bytes: 00 A0 00 E0 00 B0
  function automatic logic [7:0] vec_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd1:    b = 8'hA0;
      3'd3:    b = 8'hE0;
      3'd5:    b = 8'hB0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/serial_loaded_rom_emulator.sv @@
// ----------------------------------------------------------------------------
// serial_loaded_rom_emulator
// ROM window on a processor bus, reloaded over a serial byte stream.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in_     | input     | in_valid / in_ready  | in_payload  (slre_pkg::in_t)
//  out_    | output    | out_valid/ out_ready | out_payload (slre_pkg::out_t)
//  cfg_    | input     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
//  One request per cycle is taken while the output is not stalled; each request
//  passes the synchronous ROM read with stage one, then the output register.
//  Throughput is set by the single-port ROM memory, one access per request.
//  Reset is synchronous and active low; the ROM needs no clearing pass: a
//  high-water mark tracks which entries were loaded, unloaded entries read as
//  zero or as the preset vector bytes. A stalled output holds the pipeline;
//  in_ready drops only when both stages are full. cfg_ready is always high.
//
module serial_loaded_rom_emulator #(
  parameter int unsigned ROM_BASE  = slre_pkg::ROM_BASE_DEF,
  parameter int unsigned ROM_DEPTH = slre_pkg::ROM_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  slre_pkg::in_t                  in_payload,
  output logic                           out_valid,
  input  logic                           out_ready,
  output slre_pkg::out_t                 out_payload,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int unsigned AW = $clog2(ROM_DEPTH);      // ROM address width
  localparam int unsigned PW = $clog2(ROM_DEPTH + 1);  // pointer, holds ROM_DEPTH
  localparam int unsigned VEC_START = ROM_DEPTH - slre_pkg::VEC_COUNT;

  // Stage one: request after the ROM read was issued
  typedef struct packed {
    logic       drive;     // bus read that hits the window while ready
    logic       loaded;    // entry was written since reset
    logic [7:0] dflt;      // reset content of the entry
    logic       echo_v;
    logic [7:0] echo_b;
    logic       done;
    logic       ready;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] marker_r,  marker_nxt;
  logic [2:0] term_cnt_r, term_cnt_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    marker_nxt   = marker_r;
    term_cnt_nxt = term_cnt_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        slre_pkg::CFG_MARKER_BYTE:      marker_nxt   = cfg_data;
        slre_pkg::CFG_TERMINATOR_COUNT: term_cnt_nxt = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r   <= slre_pkg::MARKER_RESET;
      term_cnt_r <= slre_pkg::TERM_COUNT_RESET;
    end else begin
      marker_r   <= marker_nxt;
      term_cnt_r <= term_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;   // stage one moves into the output register
  logic accept;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Loader state and request decode
  // ---------------------------------------------------------------------------
  logic          ready_r,  ready_nxt;
  logic [PW-1:0] wptr_r,   wptr_nxt;
  logic [PW-1:0] hwm_r,    hwm_nxt;    // entries below this were written
  logic [2:0]    run_r,    run_nxt;

  logic [16:0]   off;
  logic          in_window;
  logic          is_marker;
  logic [2:0]    need;
  logic [2:0]    run_inc;
  logic          mem_we;
  logic          mem_re;
  s1_t           s1_r, s1_nxt;

  assign off       = {1'b0, in_payload.bus_address} - 17'(ROM_BASE);
  assign in_window = (in_payload.bus_address >= 16'(ROM_BASE)) &&
                     (off < 17'(ROM_DEPTH));
  assign is_marker = (in_payload.serial_byte == marker_r);
  assign need      = (term_cnt_r == 3'd0) ? 3'd1 : term_cnt_r;
  assign run_inc   = (run_r < slre_pkg::RUN_MAX) ? run_r + 3'd1 : run_r;

  always_comb begin
    ready_nxt = ready_r;
    wptr_nxt  = wptr_r;
    hwm_nxt   = hwm_r;
    run_nxt   = run_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    s1_nxt    = '0;

    if (in_payload.action == slre_pkg::ACT_SERIAL) begin
      if (ready_r) begin
        // Marker while idle: open a load, nothing echoed or stored
        if (is_marker) begin
          wptr_nxt  = '0;
          run_nxt   = '0;
          ready_nxt = 1'b0;
        end
      end else begin
        s1_nxt.echo_v = 1'b1;
        s1_nxt.echo_b = in_payload.serial_byte;
        // Drop bytes past the end of the ROM
        if (wptr_r < PW'(ROM_DEPTH)) begin
          mem_we   = 1'b1;
          wptr_nxt = wptr_r + PW'(1);
          if (wptr_r >= hwm_r) begin
            hwm_nxt = wptr_r + PW'(1);
          end
        end
        if (is_marker) begin
          if (run_inc >= need) begin
            ready_nxt   = 1'b1;
            s1_nxt.done = 1'b1;
            run_nxt     = '0;
          end else begin
            run_nxt = run_inc;
          end
        end else begin
          run_nxt = '0;
        end
      end
    end else begin
      if (ready_r && in_window) begin
        mem_re        = 1'b1;
        s1_nxt.drive  = 1'b1;
        s1_nxt.loaded = (17'(hwm_r) > off);
        if (off >= 17'(VEC_START)) begin
          s1_nxt.dflt = slre_pkg::vec_byte(3'(off - 17'(VEC_START)));
        end
      end
    end
    s1_nxt.ready = ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b1;
      wptr_r  <= '0;
      hwm_r   <= '0;
      run_r   <= '0;
    end else if (accept) begin
      ready_r <= ready_nxt;
      wptr_r  <= wptr_nxt;
      hwm_r   <= hwm_nxt;
      run_r   <= run_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // ROM memory: one access per request, read data held while stage one stalls
  // ---------------------------------------------------------------------------
  logic [7:0] rom_mem [ROM_DEPTH];
  logic [7:0] rom_rdata_r;

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      rom_mem[wptr_r[AW-1:0]] <= in_payload.serial_byte;
    end
    if (accept && mem_re) begin
      rom_rdata_r <= rom_mem[off[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one and output register
  // ---------------------------------------------------------------------------
  slre_pkg::out_t out_r, out_nxt;

  assign s1_valid_nxt  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);

  always_comb begin
    out_nxt.drive_enable = s1_r.drive;
    out_nxt.bus_data     = '0;
    if (s1_r.drive) begin
      out_nxt.bus_data = s1_r.loaded ? rom_rdata_r : s1_r.dflt;
    end
    out_nxt.echo_valid = s1_r.echo_v;
    out_nxt.echo_byte  = s1_r.echo_b;
    out_nxt.load_done  = s1_r.done;
    out_nxt.ready_led  = s1_r.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule
